// ===== rtl/pks_pkg.sv =====
// Package for the PRESENT key schedule unit: widths, the job type and the S-box.
// No dependencies; every other file of the block depends on it.
package pks_pkg;

    localparam int KEY_W       = 128;
    localparam int RK_W        = 64;
    localparam int ROUND_W     = 6;
    localparam int CTR_W       = 5;
    localparam int ROUND_KEYS  = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic               wide;
        logic [KEY_W-1:0]   key;
    } pks_job_t;

    localparam logic [3:0] SBOX [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };

    function automatic logic [3:0] sbox(input logic [3:0] x);
        return SBOX[x];
    endfunction

endpackage

// ===== rtl/pks_if.sv =====
// Handshake interfaces of the PRESENT key schedule unit: the key channel and the
// round key channel. Depends on pks_pkg for the field widths.
interface pks_key_if;
    logic                      valid;
    logic                      ready;
    logic [pks_pkg::RK_W-1:0]  key_low;
    logic [pks_pkg::RK_W-1:0]  key_high;

    modport source (output valid, output key_low, output key_high, input ready);
    modport sink   (input valid, input key_low, input key_high, output ready);
endinterface

interface pks_round_if;
    logic                         valid;
    logic                         ready;
    logic [pks_pkg::RK_W-1:0]     round_key;
    logic [pks_pkg::ROUND_W-1:0]  round_number;
    logic                         last_key;

    modport source (output valid, output round_key, output round_number, output last_key,
                    input ready);
    modport sink   (input valid, input round_key, input round_number, input last_key,
                    output ready);
endinterface

// ===== rtl/pks_key_queue.sv =====
// Front part of the key schedule unit: holds the mode register, tags and masks
// each incoming key and keeps it in a short queue. Depends on pks_pkg, pks_if.
module pks_key_queue #(
    parameter int DEPTH = pks_pkg::QUEUE_DEPTH
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic              cfg_write_data,
    pks_key_if.sink           key_in,
    output logic              job_valid,
    output pks_pkg::pks_job_t job,
    input  logic              job_take
);
    import pks_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pks_job_t           entry_reg [DEPTH];
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               mode_reg, mode_next;
    logic               push;
    pks_job_t           new_job;

    assign key_in.ready = (count_reg != CNT_W'(DEPTH));
    assign push         = key_in.valid && key_in.ready;
    assign job_valid    = (count_reg != '0);
    assign job          = entry_reg[head_reg];

    always_comb
    begin
        new_job.wide = mode_reg;
        new_job.key  = {mode_reg ? key_in.key_high : {48'b0, key_in.key_high[15:0]},
                        key_in.key_low};
        mode_next    = cfg_write_en ? cfg_write_data : mode_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        if (push)
        begin
            tail_next = (tail_reg == PTR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (job_take)
        begin
            head_next = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push && !job_take)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && job_take)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
            mode_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
            mode_reg  <= mode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[tail_reg] <= new_job;
        end
    end

endmodule

// ===== rtl/pks_round_engine.sv =====
// Back part of the key schedule unit: the key register, the round counter and
// the registered round key output. Depends on pks_pkg and pks_if.
module pks_round_engine (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  pks_pkg::pks_job_t job,
    output logic              job_take,
    pks_round_if.source       round_out
);
    import pks_pkg::*;

    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUND_KEYS);

    logic [KEY_W-1:0]    key_reg, key_next;
    logic [ROUND_W-1:0]  round_reg, round_next;
    logic                wide_reg, wide_next;
    logic                active_reg, active_next;
    logic                out_valid_reg, out_valid_next;
    logic [RK_W-1:0]     out_key_reg, out_key_next;
    logic [ROUND_W-1:0]  out_round_reg, out_round_next;
    logic                out_last_reg, out_last_next;
    logic                emit;
    logic                last_round;

    function automatic logic [KEY_W-1:0] update80(input logic [KEY_W-1:0] k,
                                                  input logic [CTR_W-1:0] c);
        logic [79:0] r;
        r          = {k[18:0], k[79:19]};
        r[79:76]   = sbox(r[79:76]);
        r[19:15]   = r[19:15] ^ c;
        return {48'b0, r};
    endfunction

    function automatic logic [KEY_W-1:0] update128(input logic [KEY_W-1:0] k,
                                                   input logic [CTR_W-1:0] c);
        logic [KEY_W-1:0] r;
        r          = {k[66:0], k[127:67]};
        r[127:124] = sbox(r[127:124]);
        r[123:120] = sbox(r[123:120]);
        r[66:62]   = r[66:62] ^ c;
        return r;
    endfunction

    assign round_out.valid        = out_valid_reg;
    assign round_out.round_key    = out_key_reg;
    assign round_out.round_number = out_round_reg;
    assign round_out.last_key     = out_last_reg;

    always_comb
    begin
        emit           = active_reg && (!out_valid_reg || round_out.ready);
        last_round     = (round_reg == LAST_ROUND);
        job_take       = job_valid && (!active_reg || (emit && last_round));
        key_next       = key_reg;
        round_next     = round_reg;
        wide_next      = wide_reg;
        active_next    = active_reg;
        out_key_next   = out_key_reg;
        out_round_next = out_round_reg;
        out_last_next  = out_last_reg;
        out_valid_next = emit || (out_valid_reg && !round_out.ready);
        if (emit)
        begin
            out_key_next   = wide_reg ? key_reg[127:64] : key_reg[79:16];
            out_round_next = round_reg;
            out_last_next  = last_round;
            if (last_round)
            begin
                active_next = 1'b0;
            end
            else
            begin
                key_next   = wide_reg ? update128(key_reg, round_reg[CTR_W-1:0])
                                      : update80(key_reg, round_reg[CTR_W-1:0]);
                round_next = round_reg + 1'b1;
            end
        end
        if (job_take)
        begin
            key_next    = job.key;
            wide_next   = job.wide;
            round_next  = ROUND_W'(1);
            active_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg     <= '0;
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            round_reg     <= round_next;
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        wide_reg      <= wide_next;
        out_key_reg   <= out_key_next;
        out_round_reg <= out_round_next;
        out_last_reg  <= out_last_next;
    end

endmodule

// ===== rtl/present_key_schedule_unit.sv =====
// Top level of the PRESENT key schedule unit (80-bit and 128-bit keys).
// Depends on pks_pkg, pks_if, pks_key_queue and pks_round_engine.
//
//   channel     direction  payload                               handshake
//   key_in      in         key_low, key_high                     valid / ready
//   round_out   out        round_key, round_number, last_key     valid / ready
//   cfg         in         cfg_write_data (key length mode)      cfg_write_en
//
// Each key yields 32 round keys, one per cycle while round_out is not stalled;
// the single round update unit in the key register loop sets that rate.
// Keys follow each other with no gap while the key queue holds the next one.
// A stalled round key waits in the output register; the queue keeps taking keys
// until it is full.
// Reset clears the queue, the round engine and the output valid at once.
module present_key_schedule_unit #(
    parameter int QUEUE_DEPTH = pks_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    pks_key_if.sink     key_in,
    pks_round_if.source round_out
);
    import pks_pkg::*;

    logic      job_valid;
    logic      job_take;
    pks_job_t  job;

    pks_key_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .key_in         (key_in),
        .job_valid      (job_valid),
        .job            (job),
        .job_take       (job_take)
    );

    pks_round_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_take  (job_take),
        .round_out (round_out)
    );

endmodule

// ===== rtl/pks_checker.sv =====
// Port-level checks of the PRESENT key schedule unit, bound to the top level.
// Depends on pks_pkg for the field widths.
module pks_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [pks_pkg::RK_W-1:0]     round_key,
    input logic [pks_pkg::ROUND_W-1:0]  round_number,
    input logic                         last_key
);
    import pks_pkg::*;

    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUND_KEYS);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(round_key)
            && $stable(round_number) && $stable(last_key))
        else $error("round key changed while stalled");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_key == (round_number == LAST_ROUND))
            && (round_number != '0))
        else $error("last key flag does not match round number");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_key |=> out_valid)
        else $error("round key run broke off before its last key");

    a_round_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_key |=>
            round_number == $past(round_number) + 1'b1)
        else $error("round number did not advance by one");

endmodule

bind present_key_schedule_unit pks_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (round_out.valid),
    .out_ready    (round_out.ready),
    .round_key    (round_out.round_key),
    .round_number (round_out.round_number),
    .last_key     (round_out.last_key)
);

// ===== tb/tb.sv =====
// Self-checking testbench for present_key_schedule_unit: sends cipher keys in both key lengths
// and checks every round key, round number and last flag against an in-bench key schedule.
// Depends on pks_pkg, pks_if and the RTL of the unit.
module tb;

    import pks_pkg::*;

    localparam int          WATCHDOG_LIMIT = 4000;
    localparam int          RANDOM_PHASES  = 8;
    localparam int          PHASE_KEYS     = 60;
    localparam logic [63:0] SBOX_NIBBLES   = 64'h2174_8FE3_DA09_B65C;

    typedef struct packed {
        logic [RK_W-1:0] key_low;
        logic [RK_W-1:0] key_high;
    } key_item_t;

    typedef struct packed {
        logic [RK_W-1:0]    round_key;
        logic [ROUND_W-1:0] round_number;
        logic               last_key;
    } round_key_t;

    logic clk;
    logic rst_n;
    logic cfg_write_en;
    logic cfg_write_data;

    pks_key_if   key_ch ();
    pks_round_if rk_ch ();

    present_key_schedule_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .key_in         (key_ch),
        .round_out      (rk_ch)
    );

    key_item_t  key_backlog [$];
    round_key_t round_expect [$];
    key_item_t  sent_key;
    round_key_t got_rk;
    round_key_t want_rk;
    logic       key_mode;
    bit         calm;
    int         idle_odds;
    int         send_hold;
    int         recv_hold;
    int         mismatches;
    int         stall_cycles;

    function automatic logic [3:0] sub_nibble(input logic [3:0] x);
        return SBOX_NIBBLES[{x, 2'b00} +: 4];
    endfunction

    function automatic void forecast_round_keys(input logic [RK_W-1:0] lo,
                                                input logic [RK_W-1:0] hi,
                                                input logic wide);
        logic [KEY_W-1:0] kr;
        round_key_t       rk;
        logic [CTR_W-1:0] ctr;
        int               i;
        kr = wide ? {hi, lo} : {48'b0, hi[15:0], lo};
        for (i = 1; i <= ROUND_KEYS; i++)
        begin
            rk.round_key    = wide ? kr[127:64] : kr[79:16];
            rk.round_number = ROUND_W'(i);
            rk.last_key     = (i == ROUND_KEYS);
            round_expect.push_back(rk);
            ctr = CTR_W'(i);
            if (wide)
            begin
                kr = {kr[66:0], kr[127:67]};
                kr[127:124] = sub_nibble(kr[127:124]);
                kr[123:120] = sub_nibble(kr[123:120]);
                kr[66:62] = kr[66:62] ^ ctr;
            end
            else
            begin
                kr[79:0] = {kr[18:0], kr[79:19]};
                kr[79:76] = sub_nibble(kr[79:76]);
                kr[19:15] = kr[19:15] ^ ctr;
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("tb: mismatch on %s: got %h, expected %h", what, got, want);
        mismatches++;
    endtask

    task automatic send_key(input logic [63:0] lo, input logic [63:0] hi);
        key_item_t item;
        item.key_low  = lo;
        item.key_high = hi;
        key_backlog.push_back(item);
    endtask

    task automatic write_key_mode(input logic m);
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= m;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        key_mode = m;
    endtask

    task automatic drain;
        while (key_backlog.size() != 0 || key_ch.valid || round_expect.size() != 0)
            @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_ch.valid    <= 1'b0;
            key_ch.key_low  <= '0;
            key_ch.key_high <= '0;
            send_hold = 0;
        end
        else
        begin
            if (key_ch.valid && key_ch.ready)
            begin
                sent_key = key_backlog.pop_front();
                forecast_round_keys(sent_key.key_low, sent_key.key_high, key_mode);
            end
            if (key_ch.valid && !key_ch.ready)
            begin
                key_ch.valid <= 1'b1;
            end
            else if (send_hold > 0)
            begin
                send_hold--;
                key_ch.valid <= 1'b0;
            end
            else if (!calm && $urandom_range(0, idle_odds) == 0)
            begin
                send_hold = $urandom_range(0, 16);
                key_ch.valid <= 1'b0;
            end
            else if (key_backlog.size() != 0)
            begin
                key_ch.valid    <= 1'b1;
                key_ch.key_low  <= key_backlog[0].key_low;
                key_ch.key_high <= key_backlog[0].key_high;
            end
            else
            begin
                key_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rk_ch.ready <= 1'b0;
            recv_hold = 0;
        end
        else
        begin
            if (rk_ch.valid && rk_ch.ready)
            begin
                got_rk.round_key    = rk_ch.round_key;
                got_rk.round_number = rk_ch.round_number;
                got_rk.last_key     = rk_ch.last_key;
                if (round_expect.size() == 0)
                begin
                    report_mismatch("unexpected round key", got_rk.round_key, '0);
                end
                else
                begin
                    want_rk = round_expect.pop_front();
                    if (got_rk.round_key !== want_rk.round_key)
                        report_mismatch("round_key", got_rk.round_key, want_rk.round_key);
                    if (got_rk.round_number !== want_rk.round_number)
                        report_mismatch("round_number", 64'(got_rk.round_number),
                                        64'(want_rk.round_number));
                    if (got_rk.last_key !== want_rk.last_key)
                        report_mismatch("last_key", 64'(got_rk.last_key),
                                        64'(want_rk.last_key));
                end
            end
            if (recv_hold > 0)
            begin
                recv_hold--;
                rk_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, idle_odds) == 0)
            begin
                recv_hold = $urandom_range(0, 16);
                rk_ch.ready <= 1'b0;
            end
            else
            begin
                rk_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((key_ch.valid && key_ch.ready) || (rk_ch.valid && rk_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial
    begin
        logic [63:0] lo;
        logic [63:0] hi;
        int          ph;
        int          n;
        int          m;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = 1'b0;
        key_mode       = 1'b0;
        calm           = 1'b0;
        idle_odds      = 10;
        mismatches     = 0;
        stall_cycles   = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        for (m = 0; m < 2; m++)
        begin
            write_key_mode(m[0]);
            @(negedge clk);
            send_key(64'h0, 64'h0);
            send_key(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
            send_key(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);
            send_key(64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
            send_key(64'h0, 64'h0000_0000_0000_FFFF);
            // Only bits that the 80-bit schedule ignores are set here.
            send_key(64'h0, 64'hFFFF_FFFF_FFFF_0000);
            send_key(64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A);
            send_key(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
            send_key(64'h0, 64'h8000_0000_0000_0000);
            send_key(64'h0, 64'h0000_0000_0000_8000);
            send_key(64'h0000_0000_0000_0001, 64'h0);
            drain();
        end

        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
                write_key_mode(1'b1);
            else if (ph == 1)
                write_key_mode(1'b0);
            else
                write_key_mode(1'($urandom_range(0, 1)));
            calm = (ph == RANDOM_PHASES - 1);
            idle_odds = $urandom_range(3, 40);
            @(negedge clk);
            for (n = 0; n < PHASE_KEYS; n++)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        lo = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
                        hi = {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
                    end
                    1:
                    begin
                        lo = {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
                        hi = {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
                    end
                    2:
                    begin
                        lo = $urandom_range(0, 1) ? '1 : '0;
                        hi = $urandom_range(0, 1) ? '1 : '0;
                        lo[$urandom_range(0, 63)] = 1'($urandom_range(0, 1));
                        hi[$urandom_range(0, 63)] = 1'($urandom_range(0, 1));
                    end
                    default:
                    begin
                        lo = {$urandom, $urandom};
                        hi = {$urandom, $urandom};
                    end
                endcase
                send_key(lo, hi);
            end
            drain();
        end

        repeat (40) @(posedge clk);
        if (mismatches == 0 && round_expect.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
